@@ rtl/polyphonic_square_tone_mixer_macros.svh @@
// Assertion macros for the polyphonic square tone mixer.
`ifndef POLYPHONIC_SQUARE_TONE_MIXER_MACROS_SVH
`define POLYPHONIC_SQUARE_TONE_MIXER_MACROS_SVH
`ifndef SYNTHESIS
`define PSTM_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PSTM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define PSTM_ASSERT(label, clk, rst_n, prop, msg)
`define PSTM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ rtl/pstm_pkg.sv @@
// Shared types and constants of the polyphonic square tone mixer.
package pstm_pkg;
  localparam int unsigned DefChannels = 64;
  localparam logic [7:0] SquareHighLimit = 8'd128;
  localparam logic [7:0] LevelMax = 8'd255;

  typedef enum logic [2:0] {
    FuncTick = 3'd0, FuncStartCh = 3'd1, FuncStartFree = 3'd2,
    FuncStopCh = 3'd3, FuncStopAll = 3'd4, FuncUpdate = 3'd5
  } func_e;

  typedef enum logic [2:0] {
    StIdle, StRead, StWrite, StDiv, StCount, StOut
  } state_e;

  typedef struct packed {
    logic        start;
    logic [13:0] dividend;
    logic [6:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [13:0] quotient;
  } div_rsp_t;
endpackage

@@ rtl/polyphonic_square_tone_mixer.sv @@
// Top level of the polyphonic square tone mixer.
// The block keeps a bank of square-wave tone channels and answers one command
// beat on the slave channel (s_axis) with exactly one result beat on the
// master channel (m_axis). A command either advances every playing channel by
// one sample and mixes them into a PWM level, starts a tone on a named or on
// the first free channel, stops one or all channels, or activates tones whose
// start time has come.
// Each command walks over the channels with one shared read-modify-write
// datapath, one channel at a time (memory read, then write back), and the
// busy and playing counts are built up channel by channel during that walk.
// A tick then runs a serial division of the mix sum (14 quotient bits, then a
// registered done flag); a tick with no sounding channel skips it.
// A final count state forms the busy flag of the addressed channel.
// The result beat is offered once the walk, the division of a tick (or its
// skip) and the count state are through. A new command is taken only after
// the result has been taken; s_axis_tready is low throughout. The result is
// held in an output register; s_axis_tready stays low until the receiver
// has taken it, so a stalled receiver simply holds the block. Reset clears
// the playing and waiting flags and valid bits of the per-channel store, so
// every channel reads as zero until first started. No clearing pass is needed.
`include "polyphonic_square_tone_mixer_macros.svh"
module polyphonic_square_tone_mixer #(
  parameter int unsigned CHANNELS = pstm_pkg::DefChannels
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: func[2:0], channel[8:3], phase_step[40:9], volume[48:41],
  // length[80:49], delay_ms[112:81], now_ms[144:113], zero fill to 152.
  input  logic [151:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: level[7:0], chosen_channel[13:8], no_channel[14],
  // channel_busy[15], busy_count[22:16], playing_count[29:23], zero fill.
  output logic [31:0]  m_axis_tdata
);
  import pstm_pkg::*;

  localparam int unsigned IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Per-channel store: phase, step, volume, length, played, start time.
  typedef struct packed {
    logic [31:0] phase;
    logic [31:0] step;
    logic [7:0]  vol;
    logic [31:0] len;
    logic [31:0] played;
    logic [31:0] start;
  } chan_t;

  chan_t mem [CHANNELS];
  chan_t rd_q, wr_data;
  logic  wr_en;
  logic [CHANNELS-1:0] valid_q, valid_d, play_q, play_d, wait_q, wait_d;

  state_e state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [2:0]  func_q;
  logic [5:0]  ch_q;
  logic [31:0] step_in_q, len_in_q, delay_q, now_q;
  logic [7:0]  vol_in_q;
  logic [13:0] sum_q, sum_d;
  logic [6:0]  n_q, n_d;
  logic [IdxW-1:0] target_q, target_d;
  logic        tvalid_ok_q, tvalid_ok_d, none_q, none_d;
  logic [7:0]  level_q, level_d;
  logic [5:0]  chosen_q, chosen_d;
  logic        obusy_q, obusy_d;
  logic [6:0]  nbusy_q, nbusy_d, nplay_q, nplay_d;
  logic        last_idx, ch_ok;
  div_req_t    div_req;
  div_rsp_t    div_rsp;
  logic [13:0] q4;
  logic [31:0] ph_n, pl_n;
  logic        free_found;
  logic [IdxW-1:0] free_idx;

  assign last_idx = (idx_q == IdxW'(CHANNELS - 1));
  assign ch_ok = ({26'd0, ch_q} < 32'(CHANNELS));

  // First free channel, found once at acceptance.
  always_comb begin
    free_found = 1'b0; free_idx = '0;
    for (int i = CHANNELS - 1; i >= 0; i--) begin
      if (!play_q[i] && !wait_q[i]) begin
        free_found = 1'b1; free_idx = IdxW'(i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[idx_q] <= wr_data;
    rd_q <= mem[idx_q];
  end

  pstm_div u_div (.clk_i, .rst_ni, .req_i(div_req), .rsp_o(div_rsp));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (s_axis_tvalid && s_axis_tready) state_d = StRead;
      StRead:  state_d = StWrite;
      StWrite: state_d = last_idx ? ((func_q == FuncTick) ? StDiv : StCount) : StRead;
      StDiv:   if (div_rsp.done) state_d = StCount;
      StCount: state_d = StOut;
      StOut:   if (m_axis_tready) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    idx_d = idx_q; valid_d = valid_q; play_d = play_q; wait_d = wait_q;
    sum_d = sum_q; n_d = n_q; target_d = target_q; tvalid_ok_d = tvalid_ok_q;
    none_d = none_q; level_d = level_q; chosen_d = chosen_q; obusy_d = obusy_q;
    nbusy_d = nbusy_q; nplay_d = nplay_q;
    wr_en = 1'b0; wr_data = valid_q[idx_q] ? rd_q : '0;
    div_req = '0;
    q4 = 14'(div_rsp.quotient >> 2);
    ph_n = 32'(wr_data.phase + wr_data.step);
    pl_n = 32'(wr_data.played + 32'd1);
    case (state_q)
      StIdle: begin
        idx_d = '0; sum_d = '0; n_d = '0; level_d = '0; chosen_d = '0; none_d = 1'b0;
        tvalid_ok_d = 1'b0; target_d = '0; nbusy_d = '0; nplay_d = '0;
        case (s_axis_tdata[2:0])
          FuncStartCh: begin
            tvalid_ok_d = ({26'd0, s_axis_tdata[8:3]} < 32'(CHANNELS));
            target_d = IdxW'(s_axis_tdata[8:3]);
            none_d = !tvalid_ok_d;
          end
          FuncStartFree: begin
            tvalid_ok_d = free_found; target_d = free_idx; none_d = !free_found;
          end
          default: ;
        endcase
        if (tvalid_ok_d) chosen_d = 6'(target_d);
      end
      StWrite: begin
        case (func_q)
          FuncTick: if (play_q[idx_q]) begin
            wr_en = 1'b1;
            wr_data.phase = ph_n; wr_data.played = pl_n;
            if (wr_data.len != 0 && pl_n >= wr_data.len) begin
              play_d[idx_q] = 1'b0; wait_d[idx_q] = 1'b0;
            end else if (wr_data.vol != 0) begin
              if (ph_n[31:24] < SquareHighLimit) sum_d = 14'(sum_q + {6'd0, wr_data.vol});
              n_d = 7'(n_q + 7'd1);
            end
          end
          FuncStartCh, FuncStartFree: if (tvalid_ok_q && idx_q == target_q) begin
            wr_en = 1'b1;
            wr_data.step = step_in_q; wr_data.vol = vol_in_q; wr_data.len = len_in_q;
            wr_data.phase = '0; wr_data.played = '0;
            wr_data.start = (delay_q != 0) ? 32'(now_q + delay_q) : '0;
            wait_d[idx_q] = (delay_q != 0); play_d[idx_q] = (delay_q == 0);
          end
          FuncStopCh, FuncStopAll: if ((func_q == FuncStopAll) ||
                                      (ch_ok && idx_q == IdxW'(ch_q))) begin
            wr_en = 1'b1; wr_data.vol = '0;
            play_d[idx_q] = 1'b0; wait_d[idx_q] = 1'b0;
          end
          FuncUpdate: if (wait_q[idx_q] && !play_q[idx_q] && now_q >= wr_data.start) begin
            wr_en = 1'b1; wr_data.phase = '0; wr_data.played = '0;
            play_d[idx_q] = 1'b1; wait_d[idx_q] = 1'b0;
          end
          default: ;
        endcase
        if (wr_en) valid_d[idx_q] = 1'b1;
        // Each channel's final flags are counted as the walk passes it.
        nbusy_d = 7'(nbusy_q + {6'd0, play_d[idx_q] | wait_d[idx_q]});
        nplay_d = 7'(nplay_q + {6'd0, play_d[idx_q]});
        idx_d = last_idx ? '0 : IdxW'(idx_q + 1'b1);
        if (last_idx && func_q == FuncTick && n_d != 0) begin
          div_req.start = 1'b1; div_req.dividend = sum_d; div_req.divisor = n_d;
        end
      end
      StDiv: begin
        if (n_q == 0) level_d = '0;
        else if (div_rsp.done) level_d = (q4 > 14'(LevelMax)) ? LevelMax : q4[7:0];
      end
      StCount: begin
        obusy_d = ch_ok && (play_q[IdxW'(ch_q)] || wait_q[IdxW'(ch_q)]);
      end
      default: ;
    endcase
  end

  // The divider finishes on its own; with no contributor there is no request.
  logic div_skip;
  assign div_skip = (state_q == StDiv) && (n_q == 0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; idx_q <= '0; valid_q <= '0; play_q <= '0; wait_q <= '0;
    end else begin
      state_q <= div_skip ? StCount : state_d;
      idx_q <= idx_d; valid_q <= valid_d; play_q <= play_d; wait_q <= wait_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle) begin
      func_q <= s_axis_tdata[2:0]; ch_q <= s_axis_tdata[8:3];
      step_in_q <= s_axis_tdata[40:9]; vol_in_q <= s_axis_tdata[48:41];
      len_in_q <= s_axis_tdata[80:49]; delay_q <= s_axis_tdata[112:81];
      now_q <= s_axis_tdata[144:113];
    end
    sum_q <= sum_d; n_q <= n_d; target_q <= target_d; tvalid_ok_q <= tvalid_ok_d;
    none_q <= none_d; level_q <= level_d; chosen_q <= chosen_d; obusy_q <= obusy_d;
    nbusy_q <= nbusy_d; nplay_q <= nplay_d;
  end

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = (state_q == StOut);
  assign m_axis_tdata = {2'b00, nplay_q, nbusy_q, obusy_q, none_q, chosen_q, level_q};

  `PSTM_ASSERT_IMPL(a_ready_excl, clk_i, rst_ni, s_axis_tready, !m_axis_tvalid,
                    "ready and result valid together")
  `PSTM_ASSERT_IMPL(a_play_wait, clk_i, rst_ni, 1'b1, (play_q & wait_q) == '0,
                    "channel both playing and waiting")
  `PSTM_ASSERT_IMPL(a_counts, clk_i, rst_ni, m_axis_tvalid,
                    m_axis_tdata[29:23] <= m_axis_tdata[22:16],
                    "playing count above busy count")
endmodule

@@ rtl/pstm_div.sv @@
// Bit-serial restoring divider for the mix sum.
module pstm_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pstm_pkg::div_req_t req_i,
  output pstm_pkg::div_rsp_t rsp_o
);
  import pstm_pkg::*;

  logic [13:0] quo_q, quo_d;
  logic [6:0]  rem_q, rem_d;
  logic [6:0]  den_q, den_d;
  logic [3:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [7:0]  trial;

  always_comb begin
    quo_d = quo_q; rem_d = rem_q; den_d = den_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    trial = {rem_q, quo_q[13]};
    if (req_i.start) begin
      quo_d = req_i.dividend; rem_d = '0; den_d = req_i.divisor;
      cnt_d = 4'd0; busy_d = 1'b1;
    end else if (busy_q) begin
      // One quotient bit per cycle; the remainder stays below the divisor.
      if (trial >= {1'b0, den_q}) begin
        rem_d = 7'(trial - {1'b0, den_q});
        quo_d = {quo_q[12:0], 1'b1};
      end else begin
        rem_d = trial[6:0];
        quo_d = {quo_q[12:0], 1'b0};
      end
      cnt_d = 4'(cnt_q + 4'd1);
      if (cnt_q == 4'd13) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d; rem_q <= rem_d; den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quotient = quo_q;
endmodule
